@@ rtl/mpm_pkg.sv @@
package mpm_pkg;

	localparam int DimW   = 13;
	localparam int FracW  = 17;
	localparam int AngW   = 16;
	localparam int CfgIdxW = 8;
	localparam int CfgDataW = 17;
	localparam int Dim2W  = 2 * DimW;
	localparam int KmW    = 18;
	localparam int Km2W   = 2 * KmW;

	localparam logic [CfgIdxW-1:0] CFG_IMAGE_WIDTH    = 8'd0;
	localparam logic [CfgIdxW-1:0] CFG_IMAGE_HEIGHT   = 8'd1;
	localparam logic [CfgIdxW-1:0] CFG_ILLUM_FRACTION = 8'd2;
	localparam logic [CfgIdxW-1:0] CFG_ROT_COS        = 8'd3;
	localparam logic [CfgIdxW-1:0] CFG_ROT_SIN        = 8'd4;

	localparam logic [7:0] ALPHA_LIT     = 8'd0;
	localparam logic [7:0] ALPHA_SHADED  = 8'd196;
	localparam logic [7:0] ALPHA_OUTSIDE = 8'd255;

	typedef struct packed {
		logic [DimW-1:0]        w;
		logic [DimW-1:0]        h;
		logic signed [AngW-1:0] rot_cos;
		logic signed [AngW-1:0] rot_sin;
		logic [Dim2W-1:0]       w2;
		logic [Km2W-1:0]        km2;
		logic                   k_neg;
	} cfg_t;

endpackage

@@ rtl/mpm_cfg.sv @@
module mpm_cfg #(
	parameter int MAX_DIM = 4096
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [mpm_pkg::CfgIdxW-1:0]        cfg_index,
	input  logic [mpm_pkg::CfgDataW-1:0]       cfg_data,
	output mpm_pkg::cfg_t                      cfg
);

	localparam logic [16:0] MaxDim = (MAX_DIM > 8191) ? 17'd8191 : 17'(MAX_DIM);

	logic [mpm_pkg::DimW-1:0]        width_q;
	logic [mpm_pkg::DimW-1:0]        height_q;
	logic [mpm_pkg::FracW-1:0]       frac_q;
	logic signed [mpm_pkg::AngW-1:0] cos_q;
	logic signed [mpm_pkg::AngW-1:0] sin_q;
	logic [mpm_pkg::DimW-1:0]        w_sat;
	logic [mpm_pkg::DimW-1:0]        h_sat;
	logic [mpm_pkg::Dim2W-1:0]       w2_q;
	logic signed [18:0]              k_c;
	logic [18:0]                     k_abs;
	logic [mpm_pkg::KmW-1:0]         km_q;
	logic                            k_neg_q;
	logic [mpm_pkg::Km2W-1:0]        km2_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 13'd256;
			height_q <= 13'd256;
			frac_q   <= 17'd32768;
			cos_q    <= -16'sd16384;
			sin_q    <= 16'sd0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				mpm_pkg::CFG_IMAGE_WIDTH:    width_q  <= cfg_data[mpm_pkg::DimW-1:0];
				mpm_pkg::CFG_IMAGE_HEIGHT:   height_q <= cfg_data[mpm_pkg::DimW-1:0];
				mpm_pkg::CFG_ILLUM_FRACTION: frac_q   <= cfg_data;
				mpm_pkg::CFG_ROT_COS:        cos_q    <= $signed(cfg_data[mpm_pkg::AngW-1:0]);
				mpm_pkg::CFG_ROT_SIN:        sin_q    <= $signed(cfg_data[mpm_pkg::AngW-1:0]);
				default: ;
			endcase
		end
	end

	always_comb begin
		w_sat = ({4'b0, width_q} > MaxDim) ? MaxDim[mpm_pkg::DimW-1:0] : width_q;
		h_sat = ({4'b0, height_q} > MaxDim) ? MaxDim[mpm_pkg::DimW-1:0] : height_q;
		k_c   = $signed({1'b0, frac_q, 1'b0}) - 19'sd65536;
		k_abs = k_c[18] ? $unsigned(-k_c) : $unsigned(k_c);
	end

	// Derived terms are registered; km2 is squared from the registered km_q.
	always_ff @(posedge clk) begin
		w2_q    <= w_sat * w_sat;
		km_q    <= k_abs[mpm_pkg::KmW-1:0];
		k_neg_q <= k_c[18];
		km2_q   <= km_q * km_q;
	end

	always_comb begin
		cfg.w       = w_sat;
		cfg.h       = h_sat;
		cfg.rot_cos = cos_q;
		cfg.rot_sin = sin_q;
		cfg.w2      = w2_q;
		cfg.km2     = km2_q;
		cfg.k_neg   = k_neg_q;
	end

endmodule

@@ rtl/moon_phase_mask_pixel_unit.sv @@
// Lunar phase mask, one pixel per item. The unit accepts one pixel coordinate
// per clock unless the pipeline holds and returns its alpha through an eight
// stage pipeline; the depth is set by the exact squared comparison, whose wide
// 36 by 54 bit product is split over two multiplier halves and a separate
// add stage. The whole pipeline holds when the output register is full and
// m_tready is low, so s_tready follows m_tready whenever that register is full.
// Configuration writes must only be made while no item is in flight.
module moon_phase_mask_pixel_unit #(
	parameter int MAX_DIM = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // pixel_x[11:0], pixel_y[23:12]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // alpha[7:0], inside_disc[8], zero[15:9]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [16:0] cfg_data
);

	mpm_pkg::cfg_t cfg;

	mpm_cfg #(.MAX_DIM(MAX_DIM)) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	logic        en;
	logic [8:1]  v;

	logic signed [13:0] dx_c, dy_c;
	logic signed [13:0] dx_s1, dy_s1;
	logic signed [27:0] dxx_c, dyy_c;
	logic [26:0]        dxx_s2, dyy_s2;
	logic signed [29:0] pxc_s2, pys_s2, pxs_s2, pyc_s2;
	logic [26:0]        d2_c;
	logic               in_s3;
	logic signed [30:0] xr_s3, yr_s3;
	logic [30:0]        xa_c, ya_c;
	logic               in_s4, xle0_s4;
	logic [57:0]        x2_s4, y2_s4;
	logic [53:0]        rs2_c;
	logic               in_s5, xle0_s5;
	logic [57:0]        x2_s5;
	logic [53:0]        arg_s5;
	logic               in_s6, xle0_s6;
	logic [57:0]        x2_s6;
	logic [62:0]        plo_s6, phi_s6;
	logic               in_s7, xle0_s7;
	logic [57:0]        x2_s7;
	logic [89:0]        rhs_s7;
	logic [89:0]        lhs_c;
	logic               lit_c;
	logic [7:0]         alpha_c;
	logic [7:0]         alpha_s8;
	logic               in_s8;

	assign en       = !v[8] || m_tready;
	assign s_tready = en;
	assign m_tvalid = v[8];
	assign m_tdata  = {7'b0, in_s8, alpha_s8};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v <= '0;
		end else if (en) begin
			v <= {v[7:1], s_tvalid};
		end
	end

	always_comb begin
		dx_c  = $signed({1'b0, s_tdata[11:0], 1'b0}) - $signed({1'b0, cfg.w});
		dy_c  = $signed({1'b0, s_tdata[23:12], 1'b0}) - $signed({1'b0, cfg.h});
		dxx_c = dx_s1 * dx_s1;
		dyy_c = dy_s1 * dy_s1;
		d2_c  = dxx_s2 + dyy_s2;
		xa_c  = xr_s3[30] ? $unsigned(-xr_s3) : $unsigned(xr_s3);
		ya_c  = yr_s3[30] ? $unsigned(-yr_s3) : $unsigned(yr_s3);
		rs2_c = {cfg.w2, 28'b0};
		lhs_c = {x2_s7, 32'b0};
		if (cfg.k_neg) begin
			lit_c = xle0_s7 && (lhs_c >= rhs_s7);
		end else begin
			lit_c = xle0_s7 || (lhs_c <= rhs_s7);
		end
		if (!in_s7) begin
			alpha_c = mpm_pkg::ALPHA_OUTSIDE;
		end else if (lit_c) begin
			alpha_c = mpm_pkg::ALPHA_LIT;
		end else begin
			alpha_c = mpm_pkg::ALPHA_SHADED;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1   <= dx_c;
			dy_s1   <= dy_c;

			dxx_s2  <= dxx_c[26:0];
			dyy_s2  <= dyy_c[26:0];
			pxc_s2  <= dx_s1 * cfg.rot_cos;
			pys_s2  <= dy_s1 * cfg.rot_sin;
			pxs_s2  <= dx_s1 * cfg.rot_sin;
			pyc_s2  <= dy_s1 * cfg.rot_cos;

			in_s3   <= d2_c < {1'b0, cfg.w2};
			xr_s3   <= pxc_s2 - pys_s2;
			yr_s3   <= pxs_s2 + pyc_s2;

			in_s4   <= in_s3;
			xle0_s4 <= xr_s3[30] || (xr_s3 == 31'sd0);
			x2_s4   <= xa_c[28:0] * xa_c[28:0];
			y2_s4   <= ya_c[28:0] * ya_c[28:0];

			in_s5   <= in_s4;
			xle0_s5 <= xle0_s4;
			x2_s5   <= x2_s4;
			arg_s5  <= ({4'b0, rs2_c} > y2_s4) ? (rs2_c - y2_s4[53:0]) : '0;

			in_s6   <= in_s5;
			xle0_s6 <= xle0_s5;
			x2_s6   <= x2_s5;
			plo_s6  <= cfg.km2 * arg_s5[26:0];
			phi_s6  <= cfg.km2 * arg_s5[53:27];

			in_s7   <= in_s6;
			xle0_s7 <= xle0_s6;
			x2_s7   <= x2_s6;
			rhs_s7  <= {phi_s6, 27'b0} + {27'b0, plo_s6};

			in_s8   <= in_s7;
			alpha_s8 <= alpha_c;
		end
	end

endmodule

@@ rtl/mpm_checker.sv @@
module mpm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_inside_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[8] |->
			(m_tdata[7:0] == mpm_pkg::ALPHA_LIT) || (m_tdata[7:0] == mpm_pkg::ALPHA_SHADED))
		else $error("inside pixel with outside alpha");

	a_outside_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[8] |-> m_tdata[7:0] == mpm_pkg::ALPHA_OUTSIDE)
		else $error("outside pixel with inside alpha");

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

endmodule

bind moon_phase_mask_pixel_unit mpm_checker u_mpm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
